/* rtl/bvd_pkg.sv */
`timescale 1ns / 1ps

package bvd_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XOR_MODE     = 2'd2;

    localparam logic [15:0] ROW_STRIDE_RESET   = 16'd40;
    localparam logic [15:0] COLUMN_COUNT_RESET = 16'd40;
    localparam logic        XOR_MODE_RESET     = 1'b0;

    // Operation codes: bit 7 set marks a literal run, the low 7 bits its length.
    localparam int LITERAL_BIT = 7;
    localparam logic [6:0] RUN_MASK = 7'h7F;

    localparam int OFFSET_W = 24;
    localparam int PROD_W   = 24;

    typedef struct packed {
        logic [15:0] row_stride;
        logic [15:0] column_count;
        logic        xor_mode;
    } bvd_cfg_t;

    // One parsed operation handed from the parser to the write stage.
    typedef struct packed {
        logic       has_write;
        logic [7:0] data;
        logic [7:0] rows;
        logic       done;
    } bvd_op_t;

    typedef struct packed {
        logic                write_valid;
        logic [OFFSET_W-1:0] write_offset;
        logic [7:0]          write_data;
        logic [7:0]          repeat_count;
        logic                apply_xor;
        logic                frame_done;
        logic                overrun;
    } bvd_res_t;

endpackage

/* rtl/bvd_fifo.sv */
`timescale 1ns / 1ps

module bvd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/bvd_front.sv */
`timescale 1ns / 1ps

module bvd_front #(
    parameter int ADDR_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         delta_byte,
    input  bvd_pkg::bvd_cfg_t  cfg,
    output logic               item_push,
    output bvd_pkg::bvd_op_t   item,
    output logic [ADDR_BITS:0] item_cursor
);

    import bvd_pkg::*;

    localparam int CUR_W = ADDR_BITS + 1;
    localparam int SUM_W = ((CUR_W > PROD_W) ? CUR_W : PROD_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(1) << ADDR_BITS;

    localparam logic [2:0] PH_COUNT   = 3'd0;
    localparam logic [2:0] PH_CODE    = 3'd1;
    localparam logic [2:0] PH_RCOUNT  = 3'd2;
    localparam logic [2:0] PH_RVALUE  = 3'd3;
    localparam logic [2:0] PH_LITERAL = 3'd4;

    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [15:0]      col_reg;
    logic [15:0]      col_next;
    logic [7:0]       ops_reg;
    logic [7:0]       ops_next;
    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;
    logic [7:0]       run_reg;
    logic [7:0]       run_next;

    logic             fin_en;
    logic [7:0]       fin_ops_in;
    logic [7:0]       ops_dec;
    logic [15:0]      col_inc;
    logic             fin_done;
    logic             done_direct;
    logic             adv_en;
    logic [7:0]       adv_rows;
    logic [PROD_W-1:0] adv_prod;
    logic [SUM_W-1:0] adv_sum;
    logic             wr_en;
    logic [7:0]       wr_rows;
    logic [7:0]       run_dec;

    assign adv_prod = cfg.row_stride * adv_rows;
    assign adv_sum  = SUM_W'(cursor_reg) + SUM_W'(adv_prod);
    assign ops_dec  = fin_ops_in - 8'd1;
    assign col_inc  = col_reg + 16'd1;
    assign run_dec  = run_reg - 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        col_next    = col_reg;
        ops_next    = ops_reg;
        cursor_next = cursor_reg;
        run_next    = run_reg;
        fin_en      = 1'b0;
        fin_ops_in  = ops_reg;
        fin_done    = 1'b0;
        done_direct = 1'b0;
        adv_en      = 1'b0;
        adv_rows    = '0;
        wr_en       = 1'b0;
        wr_rows     = '0;

        case (phase_reg)
            PH_CODE:
            begin
                if (delta_byte == 8'd0)
                begin
                    phase_next = PH_RCOUNT;
                end
                else if (!delta_byte[LITERAL_BIT])
                begin
                    adv_en   = 1'b1;
                    adv_rows = delta_byte;
                    fin_en   = 1'b1;
                end
                else if ((delta_byte[6:0] & RUN_MASK) == 7'd0)
                begin
                    fin_en = 1'b1;
                end
                else
                begin
                    run_next   = {1'b0, delta_byte[6:0] & RUN_MASK};
                    phase_next = PH_LITERAL;
                end
            end
            PH_RCOUNT:
            begin
                run_next   = delta_byte;
                phase_next = PH_RVALUE;
            end
            PH_RVALUE:
            begin
                if (run_reg != 8'd0)
                begin
                    wr_en    = 1'b1;
                    wr_rows  = run_reg;
                    adv_en   = 1'b1;
                    adv_rows = run_reg;
                end
                run_next = '0;
                fin_en   = 1'b1;
            end
            PH_LITERAL:
            begin
                wr_en    = 1'b1;
                wr_rows  = 8'd1;
                adv_en   = 1'b1;
                adv_rows = 8'd1;
                run_next = run_dec;
                if (run_dec == 8'd0)
                begin
                    fin_en = 1'b1;
                end
            end
            default:
            begin
                // Expecting an operation count; past the last column the byte only ends the frame.
                if (col_reg >= cfg.column_count)
                begin
                    col_next    = '0;
                    phase_next  = PH_COUNT;
                    done_direct = 1'b1;
                end
                else
                begin
                    cursor_next = CUR_W'(col_reg);
                    ops_next    = delta_byte;
                    run_next    = '0;
                    if (delta_byte == 8'd0)
                    begin
                        fin_en     = 1'b1;
                        fin_ops_in = 8'd1;
                    end
                    else
                    begin
                        phase_next = PH_CODE;
                    end
                end
            end
        endcase

        if (adv_en)
        begin
            cursor_next = (adv_sum > LIMIT) ? CUR_W'(LIMIT) : CUR_W'(adv_sum);
        end

        if (fin_en)
        begin
            if (ops_dec != 8'd0)
            begin
                phase_next = PH_CODE;
                ops_next   = ops_dec;
            end
            else
            begin
                phase_next = PH_COUNT;
                ops_next   = '0;
                if ((col_inc >= cfg.column_count) || (col_inc == 16'd0))
                begin
                    col_next = '0;
                    fin_done = 1'b1;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
        end
    end

    assign item_push      = accept && (wr_en || done_direct || fin_done);
    assign item.has_write = wr_en;
    assign item.data      = delta_byte;
    assign item.rows      = wr_rows;
    assign item.done      = done_direct || fin_done;
    assign item_cursor    = cursor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_COUNT;
            col_reg    <= '0;
            ops_reg    <= '0;
            cursor_reg <= '0;
            run_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            ops_reg    <= ops_next;
            cursor_reg <= cursor_next;
            run_reg    <= run_next;
        end
    end

    // The cursor saturates at the end of the plane and never passes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(cursor_reg) <= LIMIT)
    else $error("cursor beyond plane limit");

    // While operation codes are expected, at least one operation is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CODE) |-> (ops_reg != 8'd0))
    else $error("operation code phase with no operations left");

    // Ending a frame always rewinds to the first column.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_push && item.done) |=> (col_reg == 16'd0 && phase_reg == PH_COUNT))
    else $error("frame end did not rewind the column index");

endmodule

/* rtl/bvd_back.sv */
`timescale 1ns / 1ps

module bvd_back #(
    parameter int ADDR_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  bvd_pkg::bvd_op_t   q_item,
    input  logic [ADDR_BITS:0] q_cursor,
    input  bvd_pkg::bvd_cfg_t  cfg,
    input  logic               out_full,
    output logic               out_push,
    output bvd_pkg::bvd_res_t  out_res
);

    import bvd_pkg::*;

    localparam int CUR_W = ADDR_BITS + 1;
    localparam int SUM_W = ((CUR_W > PROD_W) ? CUR_W : PROD_W) + 1;
    localparam logic [SUM_W-1:0] LIMIT = SUM_W'(1) << ADDR_BITS;

    logic              s1_v_reg;
    logic              s1_v_next;
    bvd_op_t           s1_item_reg;
    logic [CUR_W-1:0]  s1_cursor_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s1_load;
    logic [7:0]        rows_m1;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  last_row;
    logic              ovr;
    logic              wr_ok;

    assign out_push = s1_v_reg && !out_full;
    assign s1_load  = !s1_v_reg || out_push;
    assign q_pop    = !q_empty && s1_load;

    // Rows past the first: the last written byte sits that many strides down.
    assign rows_m1 = q_item.rows - 8'd1;
    assign prod    = cfg.row_stride * rows_m1;

    assign last_row = SUM_W'(s1_cursor_reg) + SUM_W'(s1_prod_reg);
    assign ovr      = s1_item_reg.has_write && (last_row >= LIMIT);
    assign wr_ok    = s1_item_reg.has_write && !ovr;

    always_comb
    begin
        out_res.write_valid  = wr_ok;
        out_res.write_offset = wr_ok ? OFFSET_W'(s1_cursor_reg) : '0;
        out_res.write_data   = wr_ok ? s1_item_reg.data : '0;
        out_res.repeat_count = wr_ok ? s1_item_reg.rows : '0;
        out_res.apply_xor    = wr_ok && cfg.xor_mode;
        out_res.frame_done   = s1_item_reg.done;
        out_res.overrun      = ovr;
    end

    assign s1_v_next = q_pop || (s1_v_reg && !out_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg   <= q_item;
            s1_cursor_reg <= q_cursor;
            s1_prod_reg   <= prod;
        end
    end

    // A result carries a write or an overrun, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !(out_res.write_valid && out_res.overrun))
    else $error("write and overrun in one result");

    // Every result has something to report.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (out_res.write_valid || out_res.overrun || out_res.frame_done))
    else $error("empty result pushed");

    // A write covers at least one row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_res.write_valid) |-> (out_res.repeat_count != 8'd0))
    else $error("write with zero repeat count");

endmodule

/* rtl/byte_vertical_delta_decoder.sv */
`timescale 1ns / 1ps

// Vertical byte delta decoder: takes one delta byte per cycle while full is
// low and turns each column's skip, literal and repeat operations into plane
// write commands (first offset, data, repeat count at row_stride, set or XOR).
// The parser feeds a four-entry operation queue; the write stage checks the
// last row of each write against the plane size over one multiply stage, and
// a four-entry result queue holds finished results. Sustained rate is one byte
// per cycle while results are popped; results pass the operation queue, the
// write stage register and the result queue. full reflects the operation queue.
// Configuration is to be written only while idle; the block does not enforce it.
module byte_vertical_delta_decoder #(
    parameter int ADDR_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            delta_byte,
    output logic                                  empty,
    input  logic                                  pop,
    output logic                                  write_valid,
    output logic [23:0]                           write_offset,
    output logic [7:0]                            write_data,
    output logic [7:0]                            repeat_count,
    output logic                                  apply_xor,
    output logic                                  frame_done,
    output logic                                  overrun,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bvd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [15:0]                           cfg_data
);

    import bvd_pkg::*;

    localparam int CUR_W    = ADDR_BITS + 1;
    localparam int OP_W     = $bits(bvd_op_t);
    localparam int MID_W    = OP_W + CUR_W;
    localparam int RES_W    = $bits(bvd_res_t);
    localparam int Q_DEPTH  = 4;

    bvd_cfg_t         cfg_reg;
    bvd_cfg_t         cfg_next;
    logic             accept;
    logic             item_push;
    bvd_op_t          item;
    logic [CUR_W-1:0] item_cursor;
    logic             mid_full;
    logic             mid_empty;
    logic             mid_pop;
    logic [MID_W-1:0] mid_rdata;
    bvd_op_t          q_item;
    logic [CUR_W-1:0] q_cursor;
    logic             res_full;
    logic             res_push;
    bvd_res_t         res_in;
    logic [RES_W-1:0] res_rdata;
    bvd_res_t         res_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ROW_STRIDE:   cfg_next.row_stride   = cfg_data;
                REG_COLUMN_COUNT: cfg_next.column_count = cfg_data;
                REG_XOR_MODE:     cfg_next.xor_mode     = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_stride   <= ROW_STRIDE_RESET;
            cfg_reg.column_count <= COLUMN_COUNT_RESET;
            cfg_reg.xor_mode     <= XOR_MODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full   = mid_full;
    assign accept = push && !mid_full;

    bvd_front #(
        .ADDR_BITS(ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .delta_byte (delta_byte),
        .cfg        (cfg_reg),
        .item_push  (item_push),
        .item       (item),
        .item_cursor(item_cursor)
    );

    bvd_fifo #(
        .WIDTH(MID_W),
        .DEPTH(Q_DEPTH)
    ) u_op_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (item_push),
        .wdata({item, item_cursor}),
        .full (mid_full),
        .pop  (mid_pop),
        .rdata(mid_rdata),
        .empty(mid_empty)
    );

    assign q_item   = mid_rdata[MID_W-1:CUR_W];
    assign q_cursor = mid_rdata[CUR_W-1:0];

    bvd_back #(
        .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mid_empty),
        .q_pop   (mid_pop),
        .q_item  (q_item),
        .q_cursor(q_cursor),
        .cfg     (cfg_reg),
        .out_full(res_full),
        .out_push(res_push),
        .out_res (res_in)
    );

    bvd_fifo #(
        .WIDTH(RES_W),
        .DEPTH(Q_DEPTH)
    ) u_res_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_in),
        .full (res_full),
        .pop  (pop),
        .rdata(res_rdata),
        .empty(empty)
    );

    assign res_out      = res_rdata;
    assign write_valid  = res_out.write_valid;
    assign write_offset = res_out.write_offset;
    assign write_data   = res_out.write_data;
    assign repeat_count = res_out.repeat_count;
    assign apply_xor    = res_out.apply_xor;
    assign frame_done   = res_out.frame_done;
    assign overrun      = res_out.overrun;

endmodule
